// File: hw/rtl/tpg_pkg.sv
`default_nettype none
package tpg_pkg;

    localparam int TIME_BITS_DEF  = 32;
    localparam int CFG_INDEX_BITS = 8;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE      = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TAP_MIN_TIME  = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TAP_MAX_TIME  = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SWIPE_GAP     = 8'd3;

    localparam logic [31:0] DEBOUNCE_RST      = 32'd20;
    localparam logic [31:0] TAP_MIN_TIME_RST  = 32'd50;
    localparam logic [31:0] TAP_MAX_TIME_RST  = 32'd500;
    localparam logic [31:0] SWIPE_GAP_RST     = 32'd300;

    localparam logic [1:0] G_NONE  = 2'd0;
    localparam logic [1:0] G_TAP   = 2'd1;
    localparam logic [1:0] G_SWIPE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_ONE      = 3'd1,
        ST_TWO      = 3'd2,
        ST_REL_NONE = 3'd3,
        ST_REL_ONE  = 3'd4
    } gst_t;

    typedef struct packed {
        logic [31:0] debounce_ticks;
        logic [31:0] tap_min_time;
        logic [31:0] tap_max_time;
        logic [31:0] swipe_gap;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage
`default_nettype wire

// File: hw/rtl/tpg_front.sv
`default_nettype none
module tpg_front #(
    parameter int TIME_BITS = tpg_pkg::TIME_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 pad,
    input  wire logic                 raw_level,
    input  wire logic [31:0]          now,
    input  wire tpg_pkg::cfg_t        cfg,
    input  wire tpg_pkg::qstat_t      qstat,
    output logic                      push,
    output logic                      push_pad,
    output logic                      push_clean,
    output logic [TIME_BITS-1:0]      push_now
);
    import tpg_pkg::*;

    logic                 last_raw_reg    [2];
    logic [TIME_BITS-1:0] change_time_reg [2];
    logic                 debounced_reg   [2];

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] held_time;
    logic                 changed;
    logic                 held;
    logic                 clean_next;

    assign in_ready  = !qstat.full;
    assign push      = in_valid && in_ready;
    assign now_t     = now[TIME_BITS-1:0];
    assign held_time = now_t - change_time_reg[pad];
    assign changed   = raw_level != last_raw_reg[pad];
    assign held      = 32'(held_time) > cfg.debounce_ticks;

    always_comb
    begin
        clean_next = debounced_reg[pad];
        if (!changed && held)
        begin
            clean_next = last_raw_reg[pad];
        end
    end

    assign push_pad   = pad;
    assign push_clean = clean_next;
    assign push_now   = now_t;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                last_raw_reg[i]    <= 1'b0;
                change_time_reg[i] <= '0;
                debounced_reg[i]   <= 1'b0;
            end
        end
        else if (push)
        begin
            if (changed)
            begin
                last_raw_reg[pad]    <= raw_level;
                change_time_reg[pad] <= now_t;
            end
            debounced_reg[pad] <= clean_next;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/tpg_fifo.sv
`default_nettype none
module tpg_fifo #(
    parameter int WIDTH = 34,
    parameter int DEPTH = tpg_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output tpg_pkg::qstat_t       qstat
);
    import tpg_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_next;

    assign pop_data    = mem_reg[rd_ptr_reg];
    assign qstat.full  = count_reg == CNT_BITS'(DEPTH);
    assign qstat.empty = count_reg == '0;

    assign wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/tpg_back.sv
`default_nettype none
module tpg_back #(
    parameter int TIME_BITS = tpg_pkg::TIME_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tpg_pkg::qstat_t      qstat,
    input  wire logic                 q_pad,
    input  wire logic                 q_clean,
    input  wire logic [TIME_BITS-1:0] q_now,
    input  wire tpg_pkg::cfg_t        cfg,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                gesture,
    output logic                      swipe_from,
    output logic                      swipe_to,
    output logic                      clean_level
);
    import tpg_pkg::*;

    gst_t                 state_reg, state_next;
    logic                 slot_pad_reg   [2];
    logic [TIME_BITS-1:0] slot_start_reg [2];
    logic [TIME_BITS-1:0] slot_end_reg   [2];
    logic                 slot_pad_next   [2];
    logic [TIME_BITS-1:0] slot_start_next [2];
    logic [TIME_BITS-1:0] slot_end_next   [2];

    logic       out_valid_reg;
    logic [1:0] gesture_reg, gesture_next;
    logic       from_reg, from_next;
    logic       to_reg, to_next;
    logic       clean_reg;

    logic                 on_slot0;
    logic [TIME_BITS-1:0] gap;
    logic [TIME_BITS-1:0] dur0;
    logic                 gap_over;
    logic                 lone_tap;
    logic [TIME_BITS-1:0] e0;
    logic [TIME_BITS-1:0] e1;
    logic [TIME_BITS-1:0] sdiff;
    logic [TIME_BITS-1:0] ediff;
    logic [TIME_BITS-1:0] dur2;
    logic                 later;
    logic                 pair_tap;
    logic                 pair_swipe;

    assign pop = !qstat.empty && (!out_valid_reg || out_ready);

    assign on_slot0 = slot_pad_reg[0] == q_pad;
    assign gap      = q_now - slot_end_reg[0];
    assign dur0     = slot_end_reg[0] - slot_start_reg[0];
    assign gap_over = 32'(gap) > cfg.swipe_gap;
    assign lone_tap = (cfg.tap_min_time < 32'(dur0)) && (32'(dur0) < cfg.tap_max_time);

    // final release: the releasing pad's slot takes the current time first
    assign e0    = on_slot0 ? q_now : slot_end_reg[0];
    assign e1    = on_slot0 ? slot_end_reg[1] : q_now;
    assign sdiff = slot_start_reg[1] - slot_start_reg[0];
    assign later = e1 >= e0;
    assign ediff = later ? (e1 - e0) : (e0 - e1);
    assign dur2  = later ? (e1 - slot_start_reg[0]) : (e0 - slot_start_reg[0]);
    assign pair_tap = (32'(sdiff) <= cfg.tap_min_time) && (32'(ediff) <= cfg.tap_min_time)
                   && (cfg.tap_min_time < 32'(dur2)) && (32'(dur2) < cfg.tap_max_time);
    assign pair_swipe = (32'(sdiff) > cfg.tap_min_time) && later
                     && (32'(ediff) > cfg.tap_min_time);

    always_comb
    begin
        state_next = state_reg;
        if (pop)
        begin
            unique case (state_reg)
                ST_ONE:
                begin
                    if (q_clean && !on_slot0)
                    begin
                        state_next = ST_TWO;
                    end
                    else if (!q_clean && on_slot0)
                    begin
                        state_next = ST_REL_NONE;
                    end
                end
                ST_TWO:
                begin
                    if (!q_clean)
                    begin
                        state_next = ST_REL_ONE;
                    end
                end
                ST_REL_NONE:
                begin
                    if (q_clean)
                    begin
                        state_next = ST_REL_ONE;
                    end
                    else if (gap_over)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_REL_ONE:
                begin
                    if (!q_clean)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = q_clean ? ST_ONE : ST_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            slot_pad_next[i]   = slot_pad_reg[i];
            slot_start_next[i] = slot_start_reg[i];
            slot_end_next[i]   = slot_end_reg[i];
        end
        gesture_next = G_NONE;
        from_next    = 1'b0;
        to_next      = 1'b0;
        unique case (state_reg)
            ST_ONE:
            begin
                if (q_clean && !on_slot0)
                begin
                    slot_pad_next[1]   = q_pad;
                    slot_start_next[1] = q_now;
                end
                else if (!q_clean && on_slot0)
                begin
                    slot_end_next[0] = q_now;
                end
            end
            ST_TWO:
            begin
                if (!q_clean)
                begin
                    slot_end_next[0] = e0;
                    slot_end_next[1] = e1;
                end
            end
            ST_REL_NONE:
            begin
                if (q_clean)
                begin
                    slot_pad_next[1]   = q_pad;
                    slot_start_next[1] = q_now;
                end
                else if (gap_over && lone_tap)
                begin
                    gesture_next = G_TAP;
                end
            end
            ST_REL_ONE:
            begin
                if (!q_clean)
                begin
                    slot_end_next[0] = e0;
                    slot_end_next[1] = e1;
                    if (pair_tap)
                    begin
                        gesture_next = G_TAP;
                    end
                    else if (pair_swipe)
                    begin
                        gesture_next = G_SWIPE;
                        from_next    = slot_pad_reg[0];
                        to_next      = slot_pad_reg[1];
                    end
                end
            end
            default:
            begin
                if (q_clean)
                begin
                    slot_pad_next[0]   = q_pad;
                    slot_start_next[0] = q_now;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                slot_pad_reg[i]   <= 1'b0;
                slot_start_reg[i] <= '0;
                slot_end_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                for (int i = 0; i < 2; i++)
                begin
                    slot_pad_reg[i]   <= slot_pad_next[i];
                    slot_start_reg[i] <= slot_start_next[i];
                    slot_end_reg[i]   <= slot_end_next[i];
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            gesture_reg <= gesture_next;
            from_reg    <= from_next;
            to_reg      <= to_next;
            clean_reg   <= q_clean;
        end
    end

    assign out_valid   = out_valid_reg;
    assign gesture     = gesture_reg;
    assign swipe_from  = from_reg;
    assign swipe_to    = to_reg;
    assign clean_level = clean_reg;

endmodule
`default_nettype wire

// File: hw/rtl/two_pad_touch_gesture_detector.sv
// Two-pad touch gesture detector.
// Input channel (in_valid/in_ready): one sample per request with pad index,
// raw touch level and a wrapping timestamp. The sample is debounced per pad
// and the clean level steps a tap/swipe gesture machine.
// Output channel (out_valid/out_ready): exactly one result per sample with
// gesture code (none, tap, swipe), swipe direction and the clean level.
// Config channel (cfg_valid/cfg_ready): cfg_index selects the debounce time,
// tap min time, tap max time or swipe gap; other indexes are dropped.
// cfg_ready is always high; write only while the block is idle.
// Throughput: one sample per cycle while out_ready is high, set by the gesture
// state update in the back end; debounce is done in the cycle of acceptance.
// A two-entry queue sits between debounce and the gesture machine, and the
// result sits in an output register.
// When out_ready is low the output register holds, the queue fills, and
// in_ready drops once two samples are waiting.
// Reset clears all pad and gesture machine state, empties the queue and loads
// the register defaults (20, 50, 500, 300).
`default_nettype none
module two_pad_touch_gesture_detector #(
    parameter int TIME_BITS = tpg_pkg::TIME_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               pad,
    input  wire logic                               raw_level,
    input  wire logic [31:0]                        now,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tpg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [31:0]                        cfg_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [1:0]                              gesture,
    output logic                                    swipe_from,
    output logic                                    swipe_to,
    output logic                                    clean_level
);
    import tpg_pkg::*;

    localparam int Q_WIDTH = TIME_BITS + 2;

    cfg_t   cfg_reg;
    qstat_t qstat;

    logic                 push;
    logic                 push_pad;
    logic                 push_clean;
    logic [TIME_BITS-1:0] push_now;
    logic                 pop;
    logic [Q_WIDTH-1:0]   pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks <= DEBOUNCE_RST;
            cfg_reg.tap_min_time   <= TAP_MIN_TIME_RST;
            cfg_reg.tap_max_time   <= TAP_MAX_TIME_RST;
            cfg_reg.swipe_gap      <= SWIPE_GAP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE:      cfg_reg.debounce_ticks <= cfg_data;
                CFG_TAP_MIN_TIME:  cfg_reg.tap_min_time   <= cfg_data;
                CFG_TAP_MAX_TIME:  cfg_reg.tap_max_time   <= cfg_data;
                CFG_SWIPE_GAP:     cfg_reg.swipe_gap      <= cfg_data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    tpg_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pad        (pad),
        .raw_level  (raw_level),
        .now        (now),
        .cfg        (cfg_reg),
        .qstat      (qstat),
        .push       (push),
        .push_pad   (push_pad),
        .push_clean (push_clean),
        .push_now   (push_now)
    );

    tpg_fifo #(
        .WIDTH (Q_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_pad, push_clean, push_now}),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    tpg_back #(
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .qstat       (qstat),
        .q_pad       (pop_data[Q_WIDTH-1]),
        .q_clean     (pop_data[Q_WIDTH-2]),
        .q_now       (pop_data[TIME_BITS-1:0]),
        .cfg         (cfg_reg),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .gesture     (gesture),
        .swipe_from  (swipe_from),
        .swipe_to    (swipe_to),
        .clean_level (clean_level)
    );

    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue reports full and empty at once");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.full |-> !push)
        else $error("sample pushed into a full queue");

    a_gesture_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (gesture == G_NONE || gesture == G_TAP || gesture == G_SWIPE))
        else $error("undefined gesture code");

    a_dir_only_on_swipe: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && gesture != G_SWIPE) |-> (!swipe_from && !swipe_to))
        else $error("swipe direction set without a swipe");

    a_pop_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid)
        else $error("popped sample did not reach the output register");

endmodule
`default_nettype wire
